FILE: hw/rtl/omce_pkg.sv
// Shared types, codes and tree-sizing helpers for the ordered multiset block.
// No dependencies; every other file in hw/rtl imports this package.
package omce_pkg;

    localparam int KEY_W      = 31;
    localparam int SUM_W      = 63;
    localparam int TREE_RADIX = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } omce_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_APPLY
    } omce_state_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             ins_pass;  // new key sorts at or before this cell
        logic             ge;        // cell is empty or its key is at or above the query
    } omce_link_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             do_insert;
        logic             do_take;
        logic [KEY_W-1:0] query;
    } omce_cell_ctl_t;

    // Node count of one level of the select tree; level 0 is the leaves
    function automatic int level_size(input int n, input int lvl);
        int s;
        s = n;
        for (int k = 0; k < lvl; k++) begin
            s = (s + TREE_RADIX - 1) / TREE_RADIX;
        end
        return s;
    endfunction

    // Registered levels needed to reduce n leaves to one node
    function automatic int tree_depth(input int n);
        int s;
        int d;
        s = n;
        d = 0;
        for (int k = 0; k < 32; k++) begin
            if (s > 1) begin
                s = (s + TREE_RADIX - 1) / TREE_RADIX;
                d = d + 1;
            end
        end
        return d;
    endfunction

    // Start of a level inside the flat node store (level 1 starts at 0)
    function automatic int level_offset(input int n, input int lvl);
        int off;
        off = 0;
        for (int k = 1; k < lvl; k++) begin
            off = off + level_size(n, k);
        end
        return off;
    endfunction

endpackage

FILE: hw/rtl/omce_cell.sv
// One slot of the sorted key chain: holds a key and its valid bit and
// shifts toward either neighbor on insert or take. Depends on omce_pkg.
module omce_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  omce_pkg::omce_cell_ctl_t ctl,
    input  omce_pkg::omce_link_t   left,
    input  omce_pkg::omce_link_t   right,
    output omce_pkg::omce_link_t   link,
    output logic                   hit
);
    import omce_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             ins_c;
    logic             ge_c;

    // Compare the stored key against the broadcast key
    assign ins_c = !valid_reg || (key_reg > ctl.query);
    assign ge_c  = !valid_reg || (key_reg >= ctl.query);

    // Mark the first occupied slot at or above the query
    assign hit = valid_reg && ge_c && !left.ge;

    assign link.valid    = valid_reg;
    assign link.key      = key_reg;
    assign link.ins_pass = ins_c;
    assign link.ge       = ge_c;

    // Open a gap for an insert or close one after a take
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctl.do_insert && ins_c)
        begin
            if (!left.ins_pass)
            begin
                valid_next = 1'b1;
                key_next   = ctl.query;
            end
            else
            begin
                valid_next = left.valid;
                key_next   = left.key;
            end
        end
        else if (ctl.do_take && valid_reg && ge_c)
        begin
            valid_next = right.valid;
            key_next   = right.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

FILE: hw/rtl/omce_select_tree.sv
// Registered OR tree that picks the key of the single flagged slot.
// One register level per level of TREE_RADIX-way grouping. Depends on omce_pkg.
module omce_select_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                      clk,
    input  logic                      leaf_hit [LEAVES],
    input  logic [omce_pkg::KEY_W-1:0] leaf_key [LEAVES],
    output logic                      sel_hit,
    output logic [omce_pkg::KEY_W-1:0] sel_key
);
    import omce_pkg::*;

    localparam int DEPTH = tree_depth(LEAVES);
    localparam int NODES = level_offset(LEAVES, DEPTH + 1);
    localparam int ROOT  = level_offset(LEAVES, DEPTH);

    logic             tree_hit_reg  [NODES];
    logic             tree_hit_next [NODES];
    logic [KEY_W-1:0] tree_key_reg  [NODES];
    logic [KEY_W-1:0] tree_key_next [NODES];

    // Reduce each group of children into one node
    for (genvar l = 1; l <= DEPTH; l++)
    begin : g_lvl
        localparam int SZ   = level_size(LEAVES, l);
        localparam int PSZ  = level_size(LEAVES, l - 1);
        localparam int OFF  = level_offset(LEAVES, l);
        localparam int POFF = level_offset(LEAVES, l - 1);
        for (genvar j = 0; j < SZ; j++)
        begin : g_node
            if (l == 1)
            begin : g_leaf
                always_comb
                begin
                    tree_hit_next[OFF + j] = 1'b0;
                    tree_key_next[OFF + j] = '0;
                    for (int c = 0; c < TREE_RADIX; c++)
                    begin
                        if (j * TREE_RADIX + c < PSZ)
                        begin
                            if (leaf_hit[j * TREE_RADIX + c])
                            begin
                                tree_hit_next[OFF + j] = 1'b1;
                                tree_key_next[OFF + j] = tree_key_next[OFF + j]
                                                       | leaf_key[j * TREE_RADIX + c];
                            end
                        end
                    end
                end
            end
            else
            begin : g_inner
                always_comb
                begin
                    tree_hit_next[OFF + j] = 1'b0;
                    tree_key_next[OFF + j] = '0;
                    for (int c = 0; c < TREE_RADIX; c++)
                    begin
                        if (j * TREE_RADIX + c < PSZ)
                        begin
                            tree_hit_next[OFF + j] = tree_hit_next[OFF + j]
                                                   | tree_hit_reg[POFF + j * TREE_RADIX + c];
                            tree_key_next[OFF + j] = tree_key_next[OFF + j]
                                                   | tree_key_reg[POFF + j * TREE_RADIX + c];
                        end
                    end
                end
            end
        end
    end

    // Advance every level each cycle
    always_ff @(posedge clk)
    begin
        tree_hit_reg <= tree_hit_next;
        tree_key_reg <= tree_key_next;
    end

    assign sel_hit = tree_hit_reg[ROOT];
    assign sel_key = tree_key_reg[ROOT];

endmodule

FILE: hw/rtl/ordered_multiset_ceiling_extract.sv
// Top level of the ordered multiset: sorted cell chain, select tree, sequencer.
// Depends on omce_pkg, omce_cell and omce_select_tree.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   operation = insert puts key_value into the store; operation = take
//   removes the smallest stored key at or above key_value and adds it to
//   a running total that saturates at 2^63 - 1.
//   Each request gives one result: result_valid is high for exactly one cycle
//   with status, taken_key and running_total. The receiver cannot stall; the
//   result must be captured in that cycle.
//   After the accepting edge the block sits in REDUCE while the flagged key
//   passes the registered select tree, then APPLY updates the store and
//   registers the result. The tree has D = ceil(log32(CAPACITY)) register
//   levels (D = 2 for 1024 slots). Busy drops in the result cycle, so the
//   next request can be taken at the edge ending it; one is in flight at a time.
//   Keys are kept sorted in a chain of CAPACITY cells; an insert shifts the
//   larger keys one cell up, a take shifts the keys above the taken one down.
//   Reset empties the store, clears the total and leaves the block idle.
//   An insert into a full store is dropped with status full.
module ordered_multiset_ceiling_extract #(
    parameter int CAPACITY = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      operation,
    input  logic [omce_pkg::KEY_W-1:0] key_value,
    output logic                      result_valid,
    output logic [1:0]                status,
    output logic [omce_pkg::KEY_W-1:0] taken_key,
    output logic [omce_pkg::SUM_W-1:0] running_total
);
    import omce_pkg::*;

    localparam int DEPTH = tree_depth(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LVL_W = $clog2(DEPTH + 1);

    omce_state_t      state_reg;
    omce_state_t      state_next;
    logic [LVL_W-1:0] lvl_reg;
    logic [LVL_W-1:0] lvl_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             op_reg;
    logic [KEY_W-1:0] query_reg;
    logic             result_valid_reg;
    logic             result_valid_next;
    omce_status_t     status_reg;
    omce_status_t     status_next;
    logic [KEY_W-1:0] taken_key_reg;
    logic [KEY_W-1:0] taken_key_next;

    logic             accept;
    logic             full;
    logic             apply_ins;
    logic             apply_take;
    logic [SUM_W:0]   sum_wide;
    logic             sel_hit;
    logic [KEY_W-1:0] sel_key;
    omce_cell_ctl_t   cell_ctl;

    omce_link_t       links     [CAPACITY];
    logic             cell_hit  [CAPACITY];
    logic [KEY_W-1:0] cell_key  [CAPACITY];

    localparam omce_link_t LINK_EDGE = '{valid: 1'b0, key: '0, ins_pass: 1'b0, ge: 1'b0};

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (count_reg == CNT_W'(CAPACITY));

    // Sorted chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        omce_link_t left_link;
        omce_link_t right_link;
        if (i == 0)
        begin : g_first
            assign left_link = LINK_EDGE;
        end
        else
        begin : g_mid_left
            assign left_link = links[i - 1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_link = LINK_EDGE;
        end
        else
        begin : g_mid_right
            assign right_link = links[i + 1];
        end
        omce_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl),
            .left  (left_link),
            .right (right_link),
            .link  (links[i]),
            .hit   (cell_hit[i])
        );
        assign cell_key[i] = links[i].key;
    end

    // Find the key of the flagged slot
    omce_select_tree #(
        .LEAVES (CAPACITY)
    ) u_select_tree (
        .clk      (clk),
        .leaf_hit (cell_hit),
        .leaf_key (cell_key),
        .sel_hit  (sel_hit),
        .sel_key  (sel_key)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (lvl_reg == LVL_W'(DEPTH - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates of each state
    always_comb
    begin
        lvl_next          = '0;
        apply_ins         = 1'b0;
        apply_take        = 1'b0;
        result_valid_next = 1'b0;
        status_next       = status_reg;
        taken_key_next    = taken_key_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                lvl_next = '0;
            end
            ST_REDUCE:
            begin
                lvl_next = lvl_reg + 1'b1;
            end
            ST_APPLY:
            begin
                result_valid_next = 1'b1;
                taken_key_next    = '0;
                if (op_reg == OP_INSERT)
                begin
                    apply_ins = !full;
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                    end
                end
                else
                begin
                    apply_take = sel_hit;
                    if (sel_hit)
                    begin
                        status_next    = STATUS_OK;
                        taken_key_next = sel_key;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                lvl_next = '0;
            end
        endcase
    end

    assign cell_ctl.do_insert = apply_ins;
    assign cell_ctl.do_take   = apply_take;
    assign cell_ctl.query     = query_reg;

    // Track occupancy and the saturating total
    assign sum_wide = {1'b0, sum_reg} + {{(SUM_W + 1 - KEY_W){1'b0}}, sel_key};

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (apply_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (apply_take)
        begin
            count_next = count_reg - 1'b1;
            sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lvl_reg          <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            lvl_reg          <= lvl_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            query_reg <= key_value;
        end
        status_reg    <= status_next;
        taken_key_reg <= taken_key_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign taken_key     = taken_key_reg;
    assign running_total = sum_reg;

    a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg == ST_APPLY))
        else $error("result strobe without an apply cycle");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg == STATUS_FULL) |-> full)
        else $error("full status while the store has room");

    a_take_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        apply_take |=> (count_reg + 1'b1 == $past(count_reg)))
        else $error("take did not free a slot");

    a_key_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && taken_key_reg != '0) |-> status_reg == STATUS_OK)
        else $error("nonzero key with a failing status");

endmodule

FILE: bench/omce_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the ordered multiset bench: a sorted copy of the stored keys,
// the saturating total, and the queue of results still owed. Depends on omce_pkg.
package omce_tb_pkg;

    import omce_pkg::*;

    localparam logic [SUM_W-1:0] TOTAL_CEIL = {SUM_W{1'b1}};

    typedef struct {
        omce_status_t     status;
        logic [KEY_W-1:0] key;
        logic [SUM_W-1:0] total;
    } result_rec_t;

    class omce_scoreboard;
        logic [KEY_W-1:0] held_keys[$];   // ascending, duplicates kept
        logic [SUM_W-1:0] total_taken;
        result_rec_t      owed_results[$];
        int               capacity;
        int               errors;
        int               checked;
        int               n_stored;
        int               n_full;
        int               n_take_hit;
        int               n_take_miss;
        int               peak_fill;

        function new(input int cap);
            capacity    = cap;
            total_taken = '0;
            errors      = 0;
            checked     = 0;
            n_stored    = 0;
            n_full      = 0;
            n_take_hit  = 0;
            n_take_miss = 0;
            peak_fill   = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function int fill();
            return held_keys.size();
        endfunction

        // Pick any key currently in the store; caller makes sure it is not empty
        function logic [KEY_W-1:0] pick_held();
            return held_keys[$urandom_range(held_keys.size() - 1)];
        endfunction

        // Apply one accepted request to the multiset copy and queue its result
        function void note_request(input logic op, input logic [KEY_W-1:0] key);
            result_rec_t    r;
            int             pos;
            logic [SUM_W:0] sum;
            r.status = STATUS_OK;
            r.key    = '0;
            pos      = 0;
            if (op == OP_INSERT)
            begin
                if (held_keys.size() >= capacity)
                begin
                    r.status = STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    while (pos < held_keys.size() && held_keys[pos] <= key)
                        pos++;
                    held_keys.insert(pos, key);
                    n_stored++;
                    if (held_keys.size() > peak_fill)
                        peak_fill = held_keys.size();
                end
            end
            else
            begin
                // ceiling: first key in sorted order that is not below the query
                while (pos < held_keys.size() && held_keys[pos] < key)
                    pos++;
                if (pos == held_keys.size())
                begin
                    r.status = STATUS_NOT_FOUND;
                    n_take_miss++;
                end
                else
                begin
                    r.key = held_keys[pos];
                    held_keys.delete(pos);
                    sum = {1'b0, total_taken} + r.key;
                    total_taken = (sum > TOTAL_CEIL) ? TOTAL_CEIL : sum[SUM_W-1:0];
                    n_take_hit++;
                end
            end
            r.total = total_taken;
            owed_results.push_back(r);
        endfunction

        // Compare one result against the oldest outstanding request
        function void check_result(input logic [1:0] st, input logic [KEY_W-1:0] k,
                                   input logic [SUM_W-1:0] tot);
            result_rec_t e;
            if (owed_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d taken_key %0d total %0d",
                       st, k, tot);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            checked++;
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (k !== e.key)
            begin
                $error("taken_key: expected %0d, got %0d", e.key, k);
                errors++;
            end
            if (tot !== e.total)
            begin
                $error("running_total: expected %0d, got %0d", e.total, tot);
                errors++;
            end
        endfunction
    endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the ordered multiset bench: clock, reset, request driver and result monitor.
// Depends on omce_pkg, omce_tb_pkg and the ordered_multiset_ceiling_extract RTL.
module tb_top;

    import omce_pkg::*;
    import omce_tb_pkg::*;

    localparam int CAPACITY      = 1024;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 130;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 operation = OP_INSERT;
    logic [KEY_W-1:0]     key_value = '0;
    logic                 busy;
    logic                 result_valid;
    logic [1:0]           status;
    logic [KEY_W-1:0]     taken_key;
    logic [SUM_W-1:0]     running_total;

    omce_scoreboard sb = new(CAPACITY);
    int             idle_pct = 0;
    int             take_pct = 50;

    ordered_multiset_ceiling_extract #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .key_value    (key_value),
        .result_valid (result_valid),
        .status       (status),
        .taken_key    (taken_key),
        .running_total(running_total)
    );

    // 4 ns clock
    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // Check every result in the cycle it is shown
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_result(status, taken_key, running_total);
    end

    // Hold a request on the ports until the block takes it
    task automatic send(input logic op, input logic [KEY_W-1:0] key);
        start     <= 1'b1;
        operation <= op;
        key_value <= key;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_request(op, key);
    endtask

    // Drop start until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Idle the sender for a while, or now and then wait for the block to empty out
    task automatic sender_pause();
        int gap;
        gap = 0;
        if ($urandom_range(59) == 0)
            drain();
        else if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(16, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly narrow keys so duplicates and near misses are common
    function automatic logic [KEY_W-1:0] random_key();
        logic [31:0] r;
        int          pick;
        r    = $urandom();
        pick = $urandom_range(9);
        if (pick < 6)
            return KEY_W'($urandom_range(63));
        else if (pick == 6)
            return ($urandom_range(1) == 1) ? {KEY_W{1'b1}} : '0;
        return r[KEY_W-1:0];
    endfunction

    // One random insert or take; queries often sit on, just below or just above a held key
    task automatic random_request();
        logic             op;
        logic [KEY_W-1:0] key;
        op  = ($urandom_range(99) < take_pct) ? OP_TAKE : OP_INSERT;
        key = random_key();
        if (op == OP_TAKE && sb.fill() > 0 && $urandom_range(9) < 5)
        begin
            key = sb.pick_held();
            case ($urandom_range(2))
                1: key = key - 1'b1;
                2: key = key + 1'b1;
                default: ;
            endcase
        end
        send(op, key);
    endtask

    task automatic random_phase(input int pct);
        idle_pct = pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            random_request();
            sender_pause();
        end
        drain();
    endtask

    // Global timeout
    initial
    begin
        #2_000_000;
        $display("FAIL ordered_multiset_ceiling_extract");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extremes, duplicates, ceilings above and below
        send(OP_TAKE, '0);
        send(OP_TAKE, {KEY_W{1'b1}});
        send(OP_INSERT, '0);
        send(OP_INSERT, {KEY_W{1'b1}});
        send(OP_INSERT, KEY_W'(100));
        send(OP_INSERT, KEY_W'(100));
        send(OP_INSERT, KEY_W'(50));
        send(OP_TAKE, KEY_W'(101));
        send(OP_TAKE, {KEY_W{1'b1}});
        send(OP_TAKE, KEY_W'(100));
        send(OP_TAKE, KEY_W'(100));
        send(OP_TAKE, KEY_W'(100));
        send(OP_TAKE, KEY_W'(1));
        send(OP_TAKE, '0);
        send(OP_TAKE, '0);
        send(OP_INSERT, {KEY_W{1'b1}});
        send(OP_INSERT, {KEY_W{1'b1}});
        send(OP_INSERT, KEY_W'(31'h2AAA_AAAA));
        send(OP_INSERT, KEY_W'(31'h5555_5555));
        send(OP_TAKE, KEY_W'(31'h2AAA_AAAB));
        send(OP_TAKE, {KEY_W{1'b1}});
        send(OP_TAKE, '0);
        send(OP_TAKE, '0);
        send(OP_TAKE, '0);
        drain();

        // Random traffic under several sender idle rates
        random_phase(0);
        random_phase(65);
        random_phase(24);

        // A few more directed requests, then a short random tail
        idle_pct = 0;
        send(OP_INSERT, '0);
        send(OP_INSERT, {KEY_W{1'b1}});
        send(OP_TAKE, '0);
        send(OP_INSERT, KEY_W'(7));
        send(OP_INSERT, KEY_W'(7));
        send(OP_TAKE, {KEY_W{1'b1}});
        take_pct = 50;
        idle_pct = 24;
        for (int n = 0; n < 40; n++)
        begin
            random_request();
            sender_pause();
        end
        start <= 1'b0;

        // Let the last results come back and make sure nothing trails them
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d keys stored, %0d inserts dropped on a full store,",
                 sb.checked, sb.n_stored, sb.n_full);
        $display("%0d takes hit, %0d missed; peak occupancy %0d of %0d, final total %0d",
                 sb.n_take_hit, sb.n_take_miss, sb.peak_fill, CAPACITY, sb.total_taken);
        if (sb.errors == 0)
            $display("PASS ordered_multiset_ceiling_extract");
        else
            $display("FAIL ordered_multiset_ceiling_extract");
        $finish;
    end

endmodule
